/* design/ihts_pkg.sv */
// Shared types and constants for the IP/transport header splitter.
package ihts_pkg;

	localparam int COUNT_BITS = 17;

	localparam logic [3:0] VER4      = 4'd4;
	localparam logic [3:0] VER6      = 4'd6;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [5:0] IP6_HDR     = 6'd40;
	localparam logic [5:0] UDP_HDR     = 6'd8;
	localparam logic [4:0] IP4_MIN_HDR = 5'd20;
	localparam logic [4:0] TCP_MIN_HDR = 5'd20;

	localparam logic [1:0] IPV_NONE = 2'd0;
	localparam logic [1:0] IPV_4    = 2'd1;
	localparam logic [1:0] IPV_6    = 2'd2;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_BAD_VERSION    = 3'd1,
		ST_SHORT_IP       = 3'd2,
		ST_LEN_MISMATCH   = 3'd3,
		ST_BAD_PROTO      = 3'd4,
		ST_SHORT_TRANSPORT = 3'd5,
		ST_TRANSPORT_LEN  = 3'd6
	} status_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic [3:0]            version;
		logic [3:0]            ihl;
		logic [15:0]           ip_len;
		logic [7:0]            proto;
		logic [15:0]           tport;
	} pkt_state_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  ip_version;
		logic [5:0]  ip_hdr_len;
		logic [5:0]  tp_hdr_len;
		logic [6:0]  payload_off;
		logic [15:0] payload_len;
	} result_t;

endpackage

/* design/ihts_capture.sv */
// Per-packet byte counter and header field capture.
module ihts_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          data_b,
	input  logic                last_b,
	input  logic                expect_udp,
	output ihts_pkg::pkt_state_t nxt
);
	import ihts_pkg::*;

	pkt_state_t cur_q;
	logic [COUNT_BITS-1:0] idx;
	logic [6:0] thoff;
	logic       known;

	assign idx = cur_q.count;

	always_comb begin
		nxt   = cur_q;
		thoff = '0;
		known = 1'b0;
		if (cur_q.count != {COUNT_BITS{1'b1}}) begin
			nxt.count = cur_q.count + COUNT_BITS'(1);
		end
		if (idx == '0) begin
			nxt.version = data_b[7:4];
			nxt.ihl     = data_b[3:0];
		end else begin
			if (cur_q.version == VER4) begin
				if (idx == COUNT_BITS'(2)) nxt.ip_len[15:8] = data_b;
				if (idx == COUNT_BITS'(3)) nxt.ip_len[7:0]  = data_b;
				if (idx == COUNT_BITS'(9)) nxt.proto        = data_b;
				thoff = {1'b0, cur_q.ihl, 2'b00};
				known = 1'b1;
			end else if (cur_q.version == VER6) begin
				if (idx == COUNT_BITS'(4)) nxt.ip_len[15:8] = data_b;
				if (idx == COUNT_BITS'(5)) nxt.ip_len[7:0]  = data_b;
				if (idx == COUNT_BITS'(6)) nxt.proto        = data_b;
				thoff = {1'b0, IP6_HDR};
				known = 1'b1;
			end
			if (known) begin
				if (expect_udp) begin
					if (idx == COUNT_BITS'(thoff + 7'd4)) nxt.tport[15:8] = data_b;
					if (idx == COUNT_BITS'(thoff + 7'd5)) nxt.tport[7:0]  = data_b;
				end else begin
					if (idx == COUNT_BITS'(thoff + 7'd12)) nxt.tport = {8'h00, data_b};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (fire) begin
			cur_q <= last_b ? '0 : nxt;
		end
	end

	// a packet end leaves a clean slate
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_b |=> cur_q == '0)
		else $error("packet state not cleared after last byte");

	// counter advances by one per byte unless saturated
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last_b && cur_q.count != {COUNT_BITS{1'b1}}
		|=> cur_q.count == $past(cur_q.count) + COUNT_BITS'(1))
		else $error("byte counter did not advance");

	// state holds while no byte moves
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> cur_q == $past(cur_q))
		else $error("packet state changed without a byte");

endmodule

/* design/ihts_eval.sv */
// End-of-packet checks and header length results.
module ihts_eval (
	input  ihts_pkg::pkt_state_t st,
	input  logic                 expect_udp,
	output ihts_pkg::result_t    res
);
	import ihts_pkg::*;

	logic [COUNT_BITS-1:0] buflen;
	logic [COUNT_BITS-1:0] iplen_w;
	logic [5:0]  hlen;
	logic [5:0]  thlen;
	logic [15:0] plen;
	logic [1:0]  ver;
	logic [7:0]  want;
	status_t     code;

	assign buflen  = st.count;
	assign iplen_w = COUNT_BITS'(st.ip_len);
	assign want    = expect_udp ? PROTO_UDP : PROTO_TCP;

	always_comb begin
		code  = ST_OK;
		hlen  = '0;
		plen  = '0;
		ver   = IPV_NONE;
		thlen = '0;
		if (st.version == VER4) begin
			ver  = IPV_4;
			hlen = {st.ihl, 2'b00};
			plen = st.ip_len - 16'(hlen);
			if (buflen < COUNT_BITS'(IP4_MIN_HDR)) begin
				code = ST_SHORT_IP;
			end else if (buflen < iplen_w || 16'(hlen) > st.ip_len) begin
				code = ST_LEN_MISMATCH;
			end
		end else if (st.version == VER6) begin
			ver  = IPV_6;
			hlen = IP6_HDR;
			plen = st.ip_len;
			if (buflen < COUNT_BITS'(IP6_HDR)) begin
				code = ST_SHORT_IP;
			end else if (buflen < iplen_w) begin
				code = ST_LEN_MISMATCH;
			end
		end else begin
			code = ST_BAD_VERSION;
		end

		if (expect_udp) begin
			thlen = UDP_HDR;
		end else begin
			thlen = {st.tport[7:4], 2'b00};
		end

		if (code == ST_OK) begin
			if (st.proto != want) begin
				code = ST_BAD_PROTO;
			end else if (expect_udp) begin
				if (plen < 16'(UDP_HDR)) begin
					code = ST_SHORT_TRANSPORT;
				end else if (st.tport != 16'h0000 && st.tport != plen) begin
					code = ST_TRANSPORT_LEN;
				end
			end else begin
				if (plen < 16'(TCP_MIN_HDR)) begin
					code = ST_SHORT_TRANSPORT;
				end else if (16'(thlen) > plen) begin
					code = ST_TRANSPORT_LEN;
				end
			end
		end

		res.status = code;
		if (code == ST_OK) begin
			res.ip_version  = ver;
			res.ip_hdr_len  = hlen;
			res.tp_hdr_len  = thlen;
			res.payload_off = 7'(hlen) + 7'(thlen);
			res.payload_len = plen - 16'(thlen);
		end else begin
			res.ip_version  = IPV_NONE;
			res.ip_hdr_len  = '0;
			res.tp_hdr_len  = '0;
			res.payload_off = '0;
			res.payload_len = '0;
		end
	end

endmodule

/* design/ip_transport_header_splitter.sv */
// Top level: byte-stream IPv4/IPv6 + TCP/UDP header splitter.
// A last byte is first held in the input byte register, then its result is registered onto out_valid.
// Throughput: one byte per cycle; set by the byte register feeding the capture/check logic.
// A result waiting in the output register stalls only the next last byte, not plain bytes.
// Reset (arst_n low, async): packet state, expect_udp and all valid flags clear to zero.
module ip_transport_header_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  ip_version,
	output logic [5:0]  ip_header_length,
	output logic [5:0]  transport_header_length,
	output logic [6:0]  payload_start,
	output logic [15:0] payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import ihts_pkg::*;

	// configuration: transport type select
	logic expect_udp_q;

	// input stage: one byte held for the capture/check logic
	logic       s1_valid_q;
	logic [7:0] s1_byte_q;
	logic       s1_last_q;
	logic       s1_adv;

	// result register
	logic    out_valid_q;
	result_t res_q;

	pkt_state_t nxt;
	result_t    res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_udp_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			expect_udp_q <= cfg_data;
		end
	end

	// plain bytes always move on; a last byte needs a free result slot
	assign s1_adv   = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			s1_byte_q <= data_byte;
			s1_last_q <= last_byte;
		end
	end

	ihts_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_adv),
		.data_b     (s1_byte_q),
		.last_b     (s1_last_q),
		.expect_udp (expect_udp_q),
		.nxt        (nxt)
	);

	// checks run on the state including the current byte
	ihts_eval u_eval (
		.st         (nxt),
		.expect_udp (expect_udp_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_last_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_last_q) begin
			res_q <= res;
		end
	end

	assign out_valid               = out_valid_q;
	assign status                  = res_q.status;
	assign ip_version              = res_q.ip_version;
	assign ip_header_length        = res_q.ip_hdr_len;
	assign transport_header_length = res_q.tp_hdr_len;
	assign payload_start           = res_q.payload_off;
	assign payload_length          = res_q.payload_len;

	// error results carry no lengths
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> ip_version == IPV_NONE
		&& ip_header_length == '0 && payload_length == '0)
		else $error("error result carries nonzero fields");

	// good results always name a version
	a_ok_version: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> ip_version != IPV_NONE)
		else $error("ok result without IP version");

	// payload start is the sum of both header lengths
	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK
		|-> payload_start == 7'(ip_header_length) + 7'(transport_header_length))
		else $error("payload start mismatch");

	// a held last byte never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(s1_adv && s1_last_q))
		else $error("result overwritten while stalled");

endmodule
